// ----- rtl/fmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fmc_pkg;

   localparam int CoordW = 35;   // signed coordinate width, holds every exact sum
   localparam int MagW   = 34;   // dividend magnitude and divisor width
   localparam logic [31:0] MinTexQ = 32'd66;   // 0.001 m in Q16.16
   localparam int TileDefault = 0;

   typedef enum logic [2:0] {
      REG_WALL_WIDTH     = 3'd0,
      REG_WALL_HEIGHT    = 3'd1,
      REG_TEXTURE_WIDTH  = 3'd2,
      REG_TEXTURE_HEIGHT = 3'd3,
      REG_PHASE_OFFSET   = 3'd4,
      REG_PIXELS_PER_M   = 3'd5,
      REG_GROUND_BAND    = 3'd6,
      REG_UPPER_PERIOD   = 3'd7
   } reg_index_type;

   // per-item data that rides alongside the remainder lanes
   typedef struct packed {
      logic                     hwrap;
      logic signed [CoordW-1:0] u_pass;
      logic                     vwrap;
      logic signed [CoordW-1:0] v_pass;
      logic [15:0]              cols;
      logic [15:0]              rows;
   } side_type;

   function automatic logic signed [CoordW-1:0] sext32(input logic [31:0] v);
      sext32 = {{(CoordW-32){v[31]}}, v};
   endfunction

   function automatic logic signed [CoordW-1:0] zext32(input logic [31:0] v);
      zext32 = {{(CoordW-32){1'b0}}, v};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/fmc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fmc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_pos;
   logic [31:0] y_pos;
   logic [15:0] source_cols;
   logic [15:0] source_rows;
   modport source (output valid, x_pos, y_pos, source_cols, source_rows, input ready);
   modport sink (input valid, x_pos, y_pos, source_cols, source_rows, output ready);
endinterface

interface fmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] column;
   logic [15:0] row;
   logic        column_mirrored;
   modport source (output valid, column, row, column_mirrored, input ready);
   modport sink (input valid, column, row, column_mirrored, output ready);
endinterface
`default_nettype wire

// ----- rtl/fmc_mod_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-lane restoring remainder pipeline, one dividend bit per stage. Lane 0 is horizontal,
// lane 1 vertical. Divisors must be held steady while busy by the user; the block does not enforce it.
module fmc_mod_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire fmc_pkg::side_type             in_side,
   input  wire logic [fmc_pkg::MagW-1:0]      in_mag [2],
   input  wire logic [1:0]                    in_neg,
   input  wire logic [fmc_pkg::MagW-1:0]      divisor [2],
   output logic                               out_valid,
   output fmc_pkg::side_type                  out_side,
   output logic [fmc_pkg::MagW-1:0]           out_rem [2],
   output logic [1:0]                         out_neg
);

   localparam int W = fmc_pkg::MagW;

   logic [W-1:0]      rem_ff   [W][2];
   logic [W-1:0]      mag_ff   [W][2];
   logic [1:0]        neg_ff   [W];
   fmc_pkg::side_type side_ff  [W];
   logic [W-1:0]      valid_ff;

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W-1:0]      rem_prev [2];
      logic [W-1:0]      mag_prev [2];
      logic [W-1:0]      rem_in   [2];
      logic [W-1:0]      mag_in   [2];
      logic              valid_prev;
      logic [1:0]        neg_prev;
      fmc_pkg::side_type side_prev;

      if (k == 0) begin : g_head
         assign rem_prev[0] = '0;
         assign rem_prev[1] = '0;
         assign mag_prev[0] = in_mag[0];
         assign mag_prev[1] = in_mag[1];
         assign valid_prev  = in_valid;
         assign neg_prev    = in_neg;
         assign side_prev   = in_side;
      end else begin : g_tail
         assign rem_prev[0] = rem_ff[k-1][0];
         assign rem_prev[1] = rem_ff[k-1][1];
         assign mag_prev[0] = mag_ff[k-1][0];
         assign mag_prev[1] = mag_ff[k-1][1];
         assign valid_prev  = valid_ff[k-1];
         assign neg_prev    = neg_ff[k-1];
         assign side_prev   = side_ff[k-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [W:0] trial;
         logic [W:0] diff;
         always_comb begin
            trial      = {rem_prev[l], mag_prev[l][W-1]};
            diff       = trial - {1'b0, divisor[l]};
            rem_in[l]  = (trial >= {1'b0, divisor[l]}) ? diff[W-1:0] : trial[W-1:0];
            mag_in[l]  = {mag_prev[l][W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k][0] <= rem_in[0];
            rem_ff[k][1] <= rem_in[1];
            mag_ff[k][0] <= mag_in[0];
            mag_ff[k][1] <= mag_in[1];
            neg_ff[k]    <= neg_prev;
            side_ff[k]   <= side_prev;
         end
      end
   end

   assign out_valid  = valid_ff[W-1];
   assign out_side   = side_ff[W-1];
   assign out_rem[0] = rem_ff[W-1][0];
   assign out_rem[1] = rem_ff[W-1][1];
   assign out_neg    = neg_ff[W-1];

`ifndef SYNTH
   a_rem_h_below: assert property (@(posedge clock) disable iff (reset)
      out_valid && divisor[0] != '0 |-> out_rem[0] < divisor[0])
      else $error("horizontal remainder not below divisor");
   a_rem_v_below: assert property (@(posedge clock) disable iff (reset)
      out_valid && divisor[1] != '0 |-> out_rem[1] < divisor[1])
      else $error("vertical remainder not below divisor");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved during stall");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// ----- rtl/facade_texture_coordinate_map_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Registered stages from req transfer to rsp valid: input register, setup,
// 34-stage remainder pipeline, sign fix, select, multiply, clamp/output.
// Throughput: one item per cycle; the whole pipeline holds while rsp is stalled.
// Reset: synchronous, active high; empties the pipeline and loads register defaults.
module facade_texture_coordinate_map_core #(
   parameter int TILE_HORIZONTALLY = fmc_pkg::TileDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fmc_req_if.sink          req,
   fmc_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int CW = fmc_pkg::CoordW;
   localparam int MW = fmc_pkg::MagW;

   // configuration
   logic [31:0] wall_width_ff, wall_height_ff, texture_width_ff, texture_height_ff;
   logic [31:0] phase_offset_ff, ppm_ff, ground_band_ff, upper_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_width_ff     <= 32'd0;
         wall_height_ff    <= 32'd0;
         texture_width_ff  <= 32'd65536;
         texture_height_ff <= 32'd65536;
         phase_offset_ff   <= 32'd0;
         ppm_ff            <= 32'd65536;
         ground_band_ff    <= 32'd0;
         upper_period_ff   <= 32'd65536;
      end else if (csr_we) begin
         case (fmc_pkg::reg_index_type'(csr_index))
            fmc_pkg::REG_WALL_WIDTH:     wall_width_ff     <= csr_wdata;
            fmc_pkg::REG_WALL_HEIGHT:    wall_height_ff    <= csr_wdata;
            fmc_pkg::REG_TEXTURE_WIDTH:  texture_width_ff  <= csr_wdata;
            fmc_pkg::REG_TEXTURE_HEIGHT: texture_height_ff <= csr_wdata;
            fmc_pkg::REG_PHASE_OFFSET:   phase_offset_ff   <= csr_wdata;
            fmc_pkg::REG_PIXELS_PER_M:   ppm_ff            <= csr_wdata;
            fmc_pkg::REG_GROUND_BAND:    ground_band_ff    <= csr_wdata;
            fmc_pkg::REG_UPPER_PERIOD:   upper_period_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [31:0]   tw_eff, th_eff;
   logic [MW-1:0] divisor [2];
   assign tw_eff = (texture_width_ff < fmc_pkg::MinTexQ) ? fmc_pkg::MinTexQ : texture_width_ff;
   assign th_eff = (texture_height_ff < fmc_pkg::MinTexQ) ? fmc_pkg::MinTexQ
                                                          : texture_height_ff;
   assign divisor[0] = (TILE_HORIZONTALLY != 0) ? {2'b00, tw_eff} : {1'b0, tw_eff, 1'b0};
   assign divisor[1] = {2'b00, upper_period_ff};

   // global pipeline enable
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 0: input register
   logic        s0_valid_ff;
   logic [31:0] s0_x_ff, s0_y_ff;
   logic [15:0] s0_cols_ff, s0_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (en) s0_valid_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff    <= req.x_pos;
         s0_y_ff    <= req.y_pos;
         s0_cols_ff <= req.source_cols;
         s0_rows_ff <= req.source_rows;
      end
   end

   // stage 1: mode decisions and dividends
   logic signed [CW-1:0] x_s, y_s, a_in, b_in;
   logic [31:0]          half_in;
   fmc_pkg::side_type    s1_side_in;
   logic [MW-1:0]        s1_mag_in [2];
   logic [1:0]           s1_neg_in;

   always_comb begin
      x_s     = fmc_pkg::sext32(s0_x_ff);
      y_s     = fmc_pkg::sext32(s0_y_ff);
      half_in = (tw_eff - wall_width_ff) >> 1;
      a_in    = x_s + fmc_pkg::sext32(phase_offset_ff);
      b_in    = y_s - fmc_pkg::zext32(ground_band_ff);
      s1_side_in.hwrap  = wall_width_ff > tw_eff;
      s1_side_in.u_pass = x_s + fmc_pkg::zext32(half_in);
      s1_side_in.vwrap  = (wall_height_ff > th_eff) && (b_in >= 0) &&
                          (upper_period_ff != 32'd0);
      s1_side_in.v_pass = y_s;
      s1_side_in.cols   = s0_cols_ff;
      s1_side_in.rows   = s0_rows_ff;
      s1_neg_in    = {b_in[CW-1], a_in[CW-1]};
      s1_mag_in[0] = a_in[CW-1] ? MW'(-a_in) : MW'(a_in);
      s1_mag_in[1] = b_in[CW-1] ? MW'(-b_in) : MW'(b_in);
   end

   logic              s1_valid_ff;
   fmc_pkg::side_type s1_side_ff;
   logic [MW-1:0]     s1_mag_ff [2];
   logic [1:0]        s1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= s0_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff   <= s1_side_in;
         s1_mag_ff[0] <= s1_mag_in[0];
         s1_mag_ff[1] <= s1_mag_in[1];
         s1_neg_ff    <= s1_neg_in;
      end
   end

   // remainder pipeline
   logic              m_valid;
   fmc_pkg::side_type m_side;
   logic [MW-1:0]     m_rem [2];
   logic [1:0]        m_neg;

   fmc_mod_pipe u_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_side   (s1_side_ff),
      .in_mag    (s1_mag_ff),
      .in_neg    (s1_neg_ff),
      .divisor   (divisor),
      .out_valid (m_valid),
      .out_side  (m_side),
      .out_rem   (m_rem),
      .out_neg   (m_neg)
   );

   // stage C: floor-mod sign fix
   logic              c_valid_ff;
   fmc_pkg::side_type c_side_ff;
   logic [MW-1:0]     c_pos_ff [2];
   logic [MW-1:0]     c_pos_in [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         c_pos_in[l] = (m_neg[l] && m_rem[l] != '0) ? divisor[l] - m_rem[l] : m_rem[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (en) c_valid_ff <= m_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         c_side_ff   <= m_side;
         c_pos_ff[0] <= c_pos_in[0];
         c_pos_ff[1] <= c_pos_in[1];
      end
   end

   // stage D: pick texture coordinates, mirror
   logic signed [CW-1:0] d_u_in, d_v_in, d_u_ff, d_v_ff;
   logic                 d_mir_in, d_mir_ff, d_valid_ff;
   logic [15:0]          d_cols_ff, d_rows_ff;

   always_comb begin
      d_mir_in = 1'b0;
      if (!c_side_ff.hwrap) begin
         d_u_in = c_side_ff.u_pass;
      end else if (TILE_HORIZONTALLY == 0 && c_pos_ff[0] >= {2'b00, tw_eff}) begin
         d_u_in   = CW'(divisor[0] - c_pos_ff[0]);
         d_mir_in = 1'b1;
      end else begin
         d_u_in = CW'(c_pos_ff[0]);
      end
      d_v_in = c_side_ff.vwrap ? fmc_pkg::zext32(ground_band_ff) + CW'(c_pos_ff[1])
                               : c_side_ff.v_pass;
   end

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else if (en) d_valid_ff <= c_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         d_u_ff    <= d_u_in;
         d_v_ff    <= d_v_in;
         d_mir_ff  <= d_mir_in;
         d_cols_ff <= c_side_ff.cols;
         d_rows_ff <= c_side_ff.rows;
      end
   end

   // stage E: low 32x32 products, high bits folded as shifted adds
   logic        e_valid_ff, e_mir_ff, e_upos_ff, e_vpos_ff;
   logic [63:0] e_uprod_ff, e_vprod_ff;
   logic [CW-1:0] e_uhi_ff, e_vhi_ff, e_uhi_in, e_vhi_in;
   logic [15:0] e_cols_ff, e_rows_ff;

   always_comb begin
      e_uhi_in = (d_u_ff[32] ? {3'b000, ppm_ff} : '0) + (d_u_ff[33] ? {2'b00, ppm_ff, 1'b0} : '0);
      e_vhi_in = (d_v_ff[32] ? {3'b000, ppm_ff} : '0) + (d_v_ff[33] ? {2'b00, ppm_ff, 1'b0} : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (en) e_valid_ff <= d_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         e_uprod_ff <= {32'd0, d_u_ff[31:0]} * {32'd0, ppm_ff};
         e_vprod_ff <= {32'd0, d_v_ff[31:0]} * {32'd0, ppm_ff};
         e_uhi_ff   <= e_uhi_in;
         e_vhi_ff   <= e_vhi_in;
         e_upos_ff  <= d_u_ff > 0;
         e_vpos_ff  <= d_v_ff > 0;
         e_mir_ff   <= d_mir_ff;
         e_cols_ff  <= d_cols_ff;
         e_rows_ff  <= d_rows_ff;
      end
   end

   // stage F: pixel index, clamp, flip
   logic [CW-1:0] upx, vpx;
   logic [15:0]   ucl, vcl, column_in, row_in, column_ff, row_ff;
   logic          mir_in, mir_ff;

   always_comb begin
      upx = {3'b000, e_uprod_ff[63:32]} + e_uhi_ff;
      vpx = {3'b000, e_vprod_ff[63:32]} + e_vhi_ff;
      if (!e_upos_ff) ucl = 16'd0;
      else if (upx > CW'(e_cols_ff - 16'd1)) ucl = e_cols_ff - 16'd1;
      else ucl = upx[15:0];
      if (!e_vpos_ff) vcl = 16'd0;
      else if (vpx > CW'(e_rows_ff - 16'd1)) vcl = e_rows_ff - 16'd1;
      else vcl = vpx[15:0];
      if (e_cols_ff == 16'd0) begin
         column_in = 16'd0;
         mir_in    = 1'b0;
      end else begin
         column_in = e_mir_ff ? e_cols_ff - 16'd1 - ucl : ucl;
         mir_in    = e_mir_ff;
      end
      row_in = (e_rows_ff == 16'd0) ? 16'd0 : e_rows_ff - 16'd1 - vcl;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= e_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         mir_ff    <= mir_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.column          = column_ff;
   assign rsp.row             = row_ff;
   assign rsp.column_mirrored = mir_ff;

endmodule
`default_nettype wire
